### src/fmc_pkg.sv
`default_nettype none
package fmc_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // CORDIC datapath: Q30 values with guard bits for gain growth
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam int unsigned CORDIC_ATAN [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // sqrt(3)/2 in Q16
    localparam logic signed [17:0] SQRT3_2_Q16 = 18'sd56756;

    localparam int PH_W = 52;   // phase voltage width
    localparam int DW   = 54;   // duty numerator width

    // register indexes
    localparam logic [1:0] CFG_SUPPLY = 2'd0;
    localparam logic [1:0] CFG_PEAK   = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic [15:0]        elec_angle;
    } t_cmd;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] compare_c;
    } t_cmp;

    typedef struct packed {
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
        logic signed [15:0] sin_q15;
        logic signed [15:0] cos_q15;
    } t_rot;

    typedef struct packed {
        logic signed [DW-1:0] duty_a;
        logic signed [DW-1:0] duty_b;
        logic signed [DW-1:0] duty_c;
    } t_num;

    typedef struct packed {
        logic [15:0] supply;
        logic [15:0] peak;
        logic [15:0] period;
    } t_cfg;

endpackage
`default_nettype wire

### src/foc_midpoint_clamp_modulator.sv
`default_nettype none
// The result word reaches the output register through 46 register stages, the first
// loaded at the accepting edge.
// Throughput: one word per cycle; the whole pipeline advances together and holds
// while the output register is full and not taken.
// Reset (synchronous, active low) clears every valid bit and loads the registers
// with supply 3072, peak 3072 and period 1000.
module foc_midpoint_clamp_modulator #(
    parameter int ANGLE_BITS      = fmc_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = fmc_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire fmc_pkg::t_cmd i_in_word,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output fmc_pkg::t_cmp      o_out_word,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);

    // Pipeline map:
    //   sincos : angle cut to table address, 24-stage CORDIC, round to Q1.15 (26)
    //   phase  : inverse Park, inverse Clarke, midpoint-clamp offset (7)
    //   duty   : saturation flags, period product, 16-bit quotient at 2 bits
    //            per stage, final select into the output register (13)

    fmc_pkg::t_cfg r_cfg;
    fmc_pkg::t_cfg n_cfg;
    logic          w_adv;
    logic          w_rot_vld;
    fmc_pkg::t_rot w_rot;
    logic          w_num_vld;
    fmc_pkg::t_num w_num;

    // Advance when the output register is empty or its word is taken.
    assign w_adv       = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_cfg_ready = 1'b1;

    // Register writes; an index beyond the list is dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                fmc_pkg::CFG_SUPPLY: n_cfg.supply = i_cfg_data;
                fmc_pkg::CFG_PEAK:   n_cfg.peak   = i_cfg_data;
                fmc_pkg::CFG_PERIOD: n_cfg.period = i_cfg_data;
                default:             n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.supply <= 16'd3072;
            r_cfg.peak   <= 16'd3072;
            r_cfg.period <= 16'd1000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    fmc_sincos #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_in_valid),
        .i_cmd   (i_in_word),
        .o_valid (w_rot_vld),
        .o_rot   (w_rot)
    );

    fmc_phase u_phase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_rot_vld),
        .i_rot   (w_rot),
        .i_peak  (r_cfg.peak),
        .o_valid (w_num_vld),
        .o_num   (w_num)
    );

    // The last duty stage is the output register.
    fmc_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_num_vld),
        .i_num   (w_num),
        .i_cfg   (r_cfg),
        .o_valid (o_out_valid),
        .o_cmp   (o_out_word)
    );

endmodule
`default_nettype wire

### src/fmc_sincos.sv
`default_nettype none
module fmc_sincos #(
    parameter int ANGLE_BITS      = fmc_pkg::ANGLE_BITS_DEF,
    parameter int SINE_TABLE_BITS = fmc_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_adv,
    input  wire logic         i_valid,
    input  wire fmc_pkg::t_cmd i_cmd,
    output logic              o_valid,
    output fmc_pkg::t_rot     o_rot
);

    localparam int CS  = fmc_pkg::CORDIC_STEPS;
    localparam int CW  = fmc_pkg::CW;
    localparam int NST = CS + 2;
    localparam logic signed [CW-1:0] HALF_LSB = 34'sd16384;
    localparam logic signed [CW-1:0] Q15_MAX  = 34'sd32767;
    localparam logic signed [CW-1:0] Q15_MIN  = -34'sd32768;

    function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + HALF_LSB) >>> 15;
        if (r > Q15_MAX) begin
            return 16'sh7fff;
        end else if (r < Q15_MIN) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    logic [ANGLE_BITS-1:0]      w_ang;
    logic [SINE_TABLE_BITS-1:0] w_addr;
    logic [31:0]                w_p;
    logic                       w_flip;
    logic signed [CW-1:0]       w_z;
    logic signed [CW-1:0]       w_xf;
    logic signed [CW-1:0]       w_yf;

    assign w_ang = ANGLE_BITS'(i_cmd.elec_angle);

    generate
        if (ANGLE_BITS >= SINE_TABLE_BITS) begin : g_cut
            assign w_addr = w_ang[ANGLE_BITS-1 -: SINE_TABLE_BITS];
        end else begin : g_pad
            assign w_addr = {w_ang, {(SINE_TABLE_BITS-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign w_p    = {w_addr, {(32-SINE_TABLE_BITS){1'b0}}};
    // second and third quadrant: turn by half a turn, negate at the end
    assign w_flip = w_p[31] ^ w_p[30];
    assign w_z    = CW'($signed({w_p[31] ^ w_flip, w_p[30:0]}));

    logic [NST-1:0]             r_vld;
    logic signed [CW-1:0]       r_x    [CS+1];
    logic signed [CW-1:0]       r_y    [CS+1];
    logic signed [CW-1:0]       r_z    [CS+1];
    logic                       r_flip [CS+1];
    logic signed [15:0]         r_vd   [CS+1];
    logic signed [15:0]         r_vq   [CS+1];
    fmc_pkg::t_rot              r_rot;

    assign w_xf = r_flip[CS] ? -r_x[CS] : r_x[CS];
    assign w_yf = r_flip[CS] ? -r_y[CS] : r_y[CS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0]    <= fmc_pkg::CORDIC_X0;
            r_y[0]    <= '0;
            r_z[0]    <= w_z;
            r_flip[0] <= w_flip;
            r_vd[0]   <= i_cmd.volt_d;
            r_vq[0]   <= i_cmd.volt_q;
            for (int i = 0; i < CS; i++) begin
                if (!r_z[i][CW-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - CW'(fmc_pkg::CORDIC_ATAN[i]);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + CW'(fmc_pkg::CORDIC_ATAN[i]);
                end
                r_flip[i+1] <= r_flip[i];
                r_vd[i+1]   <= r_vd[i];
                r_vq[i+1]   <= r_vq[i];
            end
            r_rot.volt_d  <= r_vd[CS];
            r_rot.volt_q  <= r_vq[CS];
            r_rot.sin_q15 <= to_q15(w_yf);
            r_rot.cos_q15 <= to_q15(w_xf);
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_rot   = r_rot;

endmodule
`default_nettype wire

### src/fmc_phase.sv
`default_nettype none
module fmc_phase (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire fmc_pkg::t_rot i_rot,
    input  wire logic [15:0]   i_peak,
    output logic               o_valid,
    output fmc_pkg::t_num      o_num
);

    localparam int PH_W = fmc_pkg::PH_W;
    localparam int DW   = fmc_pkg::DW;
    localparam int NST  = 7;

    logic [NST-1:0]         r_vld;
    logic signed [31:0]     r_cd, r_sq, r_sd, r_cq;
    logic signed [32:0]     r_al, r_be, r_al3;
    logic signed [PH_W-1:0] r_kb;
    logic signed [PH_W-1:0] r_u4 [3];
    logic signed [PH_W-1:0] r_u5 [3];
    logic signed [PH_W-1:0] r_u6 [3];
    logic signed [PH_W-1:0] r_mx, r_mn;
    logic signed [DW-1:0]   r_off;
    logic signed [DW-1:0]   r_d  [3];
    logic signed [PH_W-1:0] w_al;
    logic signed [PH_W-1:0] w_mx_ab, w_mn_ab;

    assign w_al    = PH_W'(r_al3);
    assign w_mx_ab = (r_u4[1] > r_u4[0]) ? r_u4[1] : r_u4[0];
    assign w_mn_ab = (r_u4[1] < r_u4[0]) ? r_u4[1] : r_u4[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // inverse Park products
            r_cd  <= i_rot.cos_q15 * i_rot.volt_d;
            r_sq  <= i_rot.sin_q15 * i_rot.volt_q;
            r_sd  <= i_rot.sin_q15 * i_rot.volt_d;
            r_cq  <= i_rot.cos_q15 * i_rot.volt_q;
            r_al  <= 33'(r_cd) - 33'(r_sq);
            r_be  <= 33'(r_sd) + 33'(r_cq);
            r_kb  <= PH_W'(r_be) * PH_W'(fmc_pkg::SQRT3_2_Q16);
            r_al3 <= r_al;
            // inverse Clarke at a common scale of 2^16
            r_u4[0] <= w_al <<< 16;
            r_u4[1] <= r_kb - (w_al <<< 15);
            r_u4[2] <= -(w_al <<< 15) - r_kb;
            r_mx    <= (r_u4[2] > w_mx_ab) ? r_u4[2] : w_mx_ab;
            r_mn    <= (r_u4[2] < w_mn_ab) ? r_u4[2] : w_mn_ab;
            r_off   <= DW'({i_peak, 31'b0}) - DW'(r_mx) - DW'(r_mn);
            for (int k = 0; k < 3; k++) begin
                r_u5[k] <= r_u4[k];
                r_u6[k] <= r_u5[k];
                r_d[k]  <= (DW'(r_u6[k]) <<< 1) + r_off;
            end
        end
    end

    assign o_valid      = r_vld[NST-1];
    assign o_num.duty_a = r_d[0];
    assign o_num.duty_b = r_d[1];
    assign o_num.duty_c = r_d[2];

endmodule
`default_nettype wire

### src/fmc_duty.sv
`default_nettype none
module fmc_duty (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic          i_valid,
    input  wire fmc_pkg::t_num i_num,
    input  wire fmc_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output fmc_pkg::t_cmp      o_cmp
);

    localparam int DW        = fmc_pkg::DW;
    localparam int LANES     = 3;
    localparam int QBITS     = 16;
    localparam int STEPS_PER = 2;
    localparam int DIV_ST    = QBITS / STEPS_PER;
    localparam int NST       = 5 + DIV_ST;

    // restoring division: remainder in the upper half, quotient shifts in below
    function automatic logic [31:0] div_stage(input logic [31:0] acc, input logic [15:0] den);
        logic [31:0] a;
        logic [16:0] t;
        logic [16:0] d;
        a = acc;
        for (int s = 0; s < STEPS_PER; s++) begin
            t = {a[31:16], a[15]};
            d = t - {1'b0, den};
            if (t >= {1'b0, den}) begin
                a = {d[15:0], a[14:0], 1'b1};
            end else begin
                a = {t[15:0], a[14:0], 1'b0};
            end
        end
        return a;
    endfunction

    logic signed [DW-1:0] w_num [LANES];
    logic [DW-1:0]        w_den;

    assign w_num[0] = i_num.duty_a;
    assign w_num[1] = i_num.duty_b;
    assign w_num[2] = i_num.duty_c;
    assign w_den    = DW'({i_cfg.supply, 32'b0});

    logic [NST-1:0] r_vld;
    logic           r_zero [NST-1][LANES];
    logic           r_full [NST-1][LANES];
    logic [47:0]    r_dm   [LANES];
    logic [39:0]    r_plo2 [LANES];
    logic [39:0]    r_plo3 [LANES];
    logic [23:0]    r_dhi  [LANES];
    logic [39:0]    r_phi  [LANES];
    logic [31:0]    r_acc  [DIV_ST+1][LANES];
    logic [15:0]    r_cmp  [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int l = 0; l < LANES; l++) begin
                r_zero[0][l] <= w_num[l][DW-1] || (w_num[l] == '0);
                r_full[0][l] <= $unsigned(w_num[l]) >= w_den;
                r_dm[l]      <= w_num[l][47:0];
                for (int k = 1; k < NST-1; k++) begin
                    r_zero[k][l] <= r_zero[k-1][l];
                    r_full[k][l] <= r_full[k-1][l];
                end
                // period * D in two partial products
                r_plo2[l]   <= i_cfg.period * r_dm[l][23:0];
                r_dhi[l]    <= r_dm[l][47:24];
                r_phi[l]    <= i_cfg.period * r_dhi[l];
                r_plo3[l]   <= r_plo2[l];
                r_acc[0][l] <= 32'(({r_phi[l], 24'b0} + {24'b0, r_plo3[l]}) >> 32);
                for (int s = 0; s < DIV_ST; s++) begin
                    r_acc[s+1][l] <= div_stage(r_acc[s][l], i_cfg.supply);
                end
                if (r_zero[NST-2][l]) begin
                    r_cmp[l] <= '0;
                end else if (r_full[NST-2][l]) begin
                    r_cmp[l] <= i_cfg.period;
                end else begin
                    r_cmp[l] <= r_acc[DIV_ST][l][15:0];
                end
            end
        end
    end

    assign o_valid         = r_vld[NST-1];
    assign o_cmp.compare_a = r_cmp[0];
    assign o_cmp.compare_b = r_cmp[1];
    assign o_cmp.compare_c = r_cmp[2];

endmodule
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;

    // Block pipeline depth; allow a margin when draining.
    localparam int PIPE_LAT = 46;
    localparam int ATAN_STEPS = 24;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    fmc_pkg::t_cmd i_in_word = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    fmc_pkg::t_cmp o_out_word;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [15:0]   i_cfg_data = '0;

    // Predictor copies of the registers
    logic [15:0] supply_v;
    logic [15:0] peak_v;
    logic [15:0] period_c;

    fmc_pkg::t_cmp cmp_queue[$];
    int            fail_count = 0;
    int            burst_left = 0;
    bit            out_stall_on = 1'b1;

    longint atan_turn[ATAN_STEPS] = '{
        536870912, 316933406, 167458907, 85004757, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    foc_midpoint_clamp_modulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Round half up to Q1.15 and saturate; >>> on longint is a floor shift.
    function automatic longint round_q15(longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // CORDIC rotation on a 10-bit table address; fold quadrants two and three.
    function automatic void rotate_addr(input logic [9:0] addr,
                                        output longint sn, output longint cs);
        logic [31:0] ph;
        bit          flip;
        longint      x, y, z, dx, dy;
        ph = {addr, 22'd0};
        flip = ((ph + 32'h4000_0000) & 32'h8000_0000) != 0;
        x = 652032874;
        y = 0;
        if (flip) ph = ph - 32'h8000_0000;
        z = longint'($signed(ph));
        for (int i = 0; i < ATAN_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_turn[i];
            end else begin
                x += dx; y -= dy; z += atan_turn[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endfunction

    function automatic logic [15:0] scale_duty(longint d, longint den, longint per);
        longint q;
        if (d <= 0) return 16'd0;
        if (d >= den) return per[15:0];
        // d < 2^48 and per < 2^16, so the product fits unsigned 64 bits
        q = longint'(($unsigned(d) * $unsigned(per)) / $unsigned(den));
        return q[15:0];
    endfunction

    function automatic fmc_pkg::t_cmp compute_compares(fmc_pkg::t_cmd c);
        longint        sn, cs, al, be, ua, ub, uc, mx, mn, off, den, per;
        fmc_pkg::t_cmp r;
        rotate_addr(c.elec_angle[15:6], sn, cs);
        al = cs * longint'(c.volt_d) - sn * longint'(c.volt_q);
        be = sn * longint'(c.volt_d) + cs * longint'(c.volt_q);
        ua = al * 65536;
        ub = -al * 32768 + 56756 * be;
        uc = -al * 32768 - 56756 * be;
        mx = ua; mn = ua;
        if (ub > mx) mx = ub;
        if (uc > mx) mx = uc;
        if (ub < mn) mn = ub;
        if (uc < mn) mn = uc;
        off = longint'(peak_v) * 64'sd2147483648 - mx - mn;
        den = longint'(supply_v) <<< 32;
        per = longint'(period_c);
        r.compare_a = scale_duty(2 * ua + off, den, per);
        r.compare_b = scale_duty(2 * ub + off, den, per);
        r.compare_c = scale_duty(2 * uc + off, den, per);
        return r;
    endfunction

    // Receiver: stall on its own pattern, compare each taken word.
    always @(posedge i_clk) begin
        fmc_pkg::t_cmp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmp_queue.size() == 0) begin
                $display("%0t: unexpected word, got %h", $time, o_out_word);
                fail_count++;
            end else begin
                want = cmp_queue.pop_front();
                if (want.compare_a !== o_out_word.compare_a) begin
                    $display("%0t: compare_a exp %0d got %0d", $time,
                             want.compare_a, o_out_word.compare_a);
                    fail_count++;
                end
                if (want.compare_b !== o_out_word.compare_b) begin
                    $display("%0t: compare_b exp %0d got %0d", $time,
                             want.compare_b, o_out_word.compare_b);
                    fail_count++;
                end
                if (want.compare_c !== o_out_word.compare_c) begin
                    $display("%0t: compare_c exp %0d got %0d", $time,
                             want.compare_c, o_out_word.compare_c);
                    fail_count++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (out_stall_on) begin
            i_out_ready <= (($time / 70) % 5 != 0) && ($urandom_range(0, 3) != 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Send one word; idle in bursts with gaps when jitter is asked for.
    task automatic send_cmd(fmc_pkg::t_cmd c, bit jitter);
        if (jitter) begin
            if (burst_left == 0) begin
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        i_in_word <= c;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cmp_queue.push_back(compute_compares(c));
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic send_fields(logic [15:0] d, logic [15:0] q, logic [15:0] a, bit jitter);
        fmc_pkg::t_cmd c;
        c.volt_d = d;
        c.volt_q = q;
        c.elec_angle = a;
        send_cmd(c, jitter);
    endtask

    // Hold until every expected word has come, then let the pipe settle.
    task automatic drain_pipe();
        while (cmp_queue.size() != 0) @(negedge i_clk);
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            fmc_pkg::CFG_SUPPLY: supply_v = val;
            fmc_pkg::CFG_PEAK:   peak_v = val;
            fmc_pkg::CFG_PERIOD: period_c = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [15:0] sup, logic [15:0] pk, logic [15:0] per);
        drain_pipe();
        write_reg(fmc_pkg::CFG_SUPPLY, sup);
        write_reg(fmc_pkg::CFG_PEAK, pk);
        write_reg(fmc_pkg::CFG_PERIOD, per);
    endtask

    // Field extremes, quadrant boundaries and zero supply / zero period.
    task automatic test_directed();
        send_fields(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_fields(16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        send_fields(16'h8000, 16'h0000, 16'h4000, 1'b0);
        send_fields(16'h0000, 16'h7FFF, 16'h8000, 1'b0);
        send_fields(16'h0000, 16'h8000, 16'hC000, 1'b0);
        send_fields(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
        send_fields(16'h8000, 16'h8000, 16'h3FFF, 1'b0);
        send_fields(16'h0100, 16'hFF00, 16'h003F, 1'b0);
        send_fields(16'h0200, 16'h0080, 16'h0040, 1'b0);
        send_fields(16'h0300, 16'h0000, 16'h5555, 1'b0);
        send_fields(16'hFFFF, 16'h0001, 16'hAAAA, 1'b0);
        set_config(16'd0, 16'd3072, 16'd1000);
        send_fields(16'h0100, 16'h0000, 16'h0000, 1'b0);
        send_fields(16'h0000, 16'h0000, 16'h2000, 1'b0);
        set_config(16'd3072, 16'd3072, 16'd0);
        send_fields(16'h0400, 16'h0200, 16'h1000, 1'b0);
        set_config(16'd1, 16'd0, 16'hFFFF);
        send_fields(16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_fields(16'h0001, 16'h0000, 16'h0000, 1'b0);
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(16'h7FFF, 16'h7FFF, 16'h1234, 1'b0);
        send_fields(16'h8000, 16'h7FFF, 16'h9000, 1'b0);
    endtask

    // Random words across several register settings.
    task automatic test_random();
        logic [15:0] d, q;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(16'd3072, 16'd3072, 16'd1000);
                1: set_config(16'hFFFF, 16'd0, 16'hFFFF);
                2: set_config(16'd1, 16'hFFFF, 16'd1);
                default: set_config(16'($urandom_range(1, 65535)), 16'($urandom),
                                    16'($urandom_range(1, 65535)));
            endcase
            out_stall_on = (ph != 3);
            for (int n = 0; n < 100; n++) begin
                // mostly modest commands so outputs land inside the clamp
                if ($urandom_range(0, 3) == 0) begin
                    d = 16'($urandom);
                    q = 16'($urandom);
                end else begin
                    d = 16'($signed($urandom_range(0, 2047)) - 1024);
                    q = 16'($signed($urandom_range(0, 2047)) - 1024);
                end
                send_fields(d, q, 16'($urandom), ph != 4);
            end
        end
    endtask

    initial begin
        supply_v = 16'd3072;
        peak_v   = 16'd3072;
        period_c = 16'd1000;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        drain_pipe();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
src/fmc_pkg.sv
src/fmc_sincos.sv
src/fmc_phase.sv
src/fmc_duty.sv
src/foc_midpoint_clamp_modulator.sv
bench/tb.sv
